// File: sv/p1305_pkg.sv
// ----------------------------------------------------------------------------
// p1305_pkg
// Shared types and constants for the Poly1305 tag block.
// ----------------------------------------------------------------------------
`default_nettype none

package p1305_pkg;

    localparam int LIMB_W = 26;
    localparam int NLIMB  = 5;

    // configuration register indexes
    localparam logic [1:0] REG_R_LOW  = 2'd0;
    localparam logic [1:0] REG_R_HIGH = 2'd1;
    localparam logic [1:0] REG_S_LOW  = 2'd2;
    localparam logic [1:0] REG_S_HIGH = 2'd3;

    localparam logic [63:0] CLAMP_LOW  = 64'h0ffffffc0fffffff;
    localparam logic [63:0] CLAMP_HIGH = 64'h0ffffffc0ffffffc;

    typedef struct packed {
        logic       load;      // take block, form h = acc + t
        logic       mac;       // one product column
        logic [2:0] col;       // column index 0..4
        logic       norm;      // carry pass over the columns
        logic       fin;       // final reduce, add s, clear acc
    } t_cmd;

endpackage

`default_nettype wire

// File: sv/p1305_if.sv
// ----------------------------------------------------------------------------
// p1305_in_if / p1305_out_if / p1305_cfg_if
// Valid/ready channels of the Poly1305 tag block.
// ----------------------------------------------------------------------------
`default_nettype none

interface p1305_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [4:0]  block_len;
    logic        is_last;
    modport source (output valid, block_low, block_high, block_len, is_last, input ready);
    modport sink   (input valid, block_low, block_high, block_len, is_last, output ready);
endinterface

interface p1305_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] tag_low;
    logic [63:0] tag_high;
    modport source (output valid, tag_low, tag_high, input ready);
    modport sink   (input valid, tag_low, tag_high, output ready);
endinterface

interface p1305_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/p1305_dp.sv
// ----------------------------------------------------------------------------
// p1305_dp
// Datapath: accumulator, five 28x29 products per column, reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module p1305_dp (
    input  wire logic              i_clk,
    input  wire p1305_pkg::t_cmd   i_cmd,
    input  wire logic [63:0]       i_block_low,
    input  wire logic [63:0]       i_block_high,
    input  wire logic [4:0]        i_block_len,
    input  wire logic [63:0]       i_r_low,
    input  wire logic [63:0]       i_r_high,
    input  wire logic [63:0]       i_s_low,
    input  wire logic [63:0]       i_s_high,
    input  wire logic              i_rst_n,
    output logic [63:0]            o_tag_low,
    output logic [63:0]            o_tag_high
);

    // limb 2 can carry one bit past 26 after the carry pass
    logic [26:0]  r_acc [5];
    logic [27:0]  r_h   [5];
    logic [63:0]  r_d   [5];
    logic [127:0] r_tag;

    // padded block
    logic [4:0]   len;
    logic [129:0] blk;
    logic [127:0] mask;
    logic [129:0] msg;
    logic [25:0]  t [5];
    logic [127:0] rk;
    logic [25:0]  rl [5];

    always_comb begin
        len  = (i_block_len > 5'd16) ? 5'd16 : i_block_len;
        blk  = {2'b00, i_block_high, i_block_low};
        mask = (len == 5'd16) ? '1 : ((128'd1 << {len[3:0], 3'b000}) - 128'd1);
        msg  = (blk & {2'b00, mask}) | (130'd1 << {len, 3'b000});
        for (int k = 0; k < 5; k++) begin
            t[k] = msg[26*k +: 26];
        end
        rk = {i_r_high & p1305_pkg::CLAMP_HIGH, i_r_low & p1305_pkg::CLAMP_LOW};
        for (int k = 0; k < 4; k++) begin
            rl[k] = rk[26*k +: 26];
        end
        rl[4] = {2'b00, rk[127:104]};
    end

    // one column: 5 products of 28x29 bits summed, using the r or 5r limb
    logic [63:0] col_sum;
    always_comb begin
        logic [28:0] f;
        logic [2:0]  j;
        col_sum = '0;
        for (int i = 0; i < 5; i++) begin
            if (i <= int'(i_cmd.col)) begin
                j = 3'(int'(i_cmd.col) - i);
                f = {3'b000, rl[j]};
            end else begin
                j = 3'(int'(i_cmd.col) + 5 - i);
                f = 29'({3'b000, rl[j]} * 29'd5);
            end
            col_sum = col_sum + 64'(56'(r_h[i]) * 56'(f));
        end
    end

    // carry pass over the column sums
    logic [26:0] nrm [5];
    always_comb begin
        logic [63:0] d0, d1, d2, d3, d4, c;
        d0 = r_d[0]; d1 = r_d[1]; d2 = r_d[2]; d3 = r_d[3]; d4 = r_d[4];
        c = d0 >> 26; d0 = d0 & 64'h3ffffff; d1 = d1 + c;
        c = d1 >> 26; d1 = d1 & 64'h3ffffff; d2 = d2 + c;
        c = d2 >> 26; d2 = d2 & 64'h3ffffff; d3 = d3 + c;
        c = d3 >> 26; d3 = d3 & 64'h3ffffff; d4 = d4 + c;
        c = d4 >> 26; d4 = d4 & 64'h3ffffff; d0 = d0 + c * 64'd5;
        c = d0 >> 26; d0 = d0 & 64'h3ffffff; d1 = d1 + c;
        c = d1 >> 26; d1 = d1 & 64'h3ffffff; d2 = d2 + c;
        nrm[0] = d0[26:0]; nrm[1] = d1[26:0]; nrm[2] = d2[26:0];
        nrm[3] = d3[26:0]; nrm[4] = d4[26:0];
    end

    // final full reduction and add s
    logic [127:0] fin_tag;
    always_comb begin
        logic [131:0] hv;
        logic [130:0] hf, gv;
        hv = 132'(r_acc[0]) + (132'(r_acc[1]) << 26) + (132'(r_acc[2]) << 52)
           + (132'(r_acc[3]) << 78) + (132'(r_acc[4]) << 104);
        // fold bits above 2^130 back in; then one conditional subtract of p
        hf = 131'(hv[129:0]) + 131'(hv[131:130]) * 131'd5;
        gv = hf + 131'd5;
        if (gv[130]) hf = gv - (131'd1 << 130);
        fin_tag = hf[127:0] + {i_s_high, i_s_low};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) r_acc[k] <= '0;
        end else if (i_cmd.norm) begin
            for (int k = 0; k < 5; k++) r_acc[k] <= nrm[k];
        end else if (i_cmd.fin) begin
            for (int k = 0; k < 5; k++) r_acc[k] <= '0;
        end
        if (i_cmd.load) begin
            for (int k = 0; k < 5; k++) r_h[k] <= 28'(r_acc[k]) + 28'(t[k]);
        end
        if (i_cmd.mac) r_d[i_cmd.col] <= col_sum;
        if (i_cmd.fin) r_tag <= fin_tag;
    end

    assign o_tag_low  = r_tag[63:0];
    assign o_tag_high = r_tag[127:64];

endmodule

`default_nettype wire

// File: sv/p1305_ctrl.sv
// ----------------------------------------------------------------------------
// p1305_ctrl
// Sequencer: load, five product columns, carry pass, optional finish.
// ----------------------------------------------------------------------------
`default_nettype none

module p1305_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [4:0]      i_in_len,
    input  wire logic            i_in_last,
    input  wire logic            i_out_ready,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output p1305_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_NORM = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [2:0] r_col, n_col;
    logic       r_last, n_last;
    logic       r_ovalid, n_ovalid;
    logic       acc;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign acc         = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_last   = r_last;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        o_cmd.col = r_col;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_last = i_in_last;
                    if (i_in_len != 5'd0) begin
                        o_cmd.load = 1'b1;
                        n_state = ST_MAC;
                        n_col = 3'd0;
                    end else if (i_in_last) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_MAC: begin
                o_cmd.mac = 1'b1;
                if (r_col == 3'd4) begin
                    n_col = 3'd0;
                    n_state = ST_NORM;
                end else begin
                    n_col = r_col + 3'd1;
                end
            end
            ST_NORM: begin
                o_cmd.norm = 1'b1;
                n_state = r_last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                // finish waits until the previous tag has been taken
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.fin = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_col    <= '0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MAC |-> r_col <= 3'd4) else $error("column out of range");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_in_ready) else $error("ready while busy");
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FIN |=> r_ovalid) else $error("tag not raised");

endmodule

`default_nettype wire

// File: sv/poly1305_mac_tag_top.sv
// ----------------------------------------------------------------------------
// poly1305_mac_tag_top
// Poly1305 one-time authenticator over 16-byte blocks.
// ----------------------------------------------------------------------------
// Channels: cfg writes key words (0 r_low, 1 r_high, 2 s_low, 3 s_high);
// r is clamped inside. in carries one block word (up to 16 bytes, length,
// last flag). out carries one 128-bit tag word per message.
// A non-empty block passes through the accepting cycle, five product columns
// on the column multipliers and a carry pass before the next block is taken.
// A last block adds a finish step that writes the tag register; an empty last
// block goes straight from the accepting cycle to the finish step. One block is
// processed at a time: no new block is accepted until its sequence is done.
// The tag sits in an output register; a stalled receiver holds it there,
// new blocks are still taken, and only the next finish step waits for the
// tag to be taken. Reset clears keys, accumulator and pending tag.
// ----------------------------------------------------------------------------
`default_nettype none

module poly1305_mac_tag_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    p1305_cfg_if.sink  cfg,
    p1305_in_if.sink   in_ch,
    p1305_out_if.source out_ch
);

    logic [63:0] r_key [4];
    p1305_pkg::t_cmd cmd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
        end else if (cfg.valid) begin
            r_key[cfg.index] <= cfg.data;
        end
    end

    p1305_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_len    (in_ch.block_len),
        .i_in_last   (in_ch.is_last),
        .i_out_ready (out_ch.ready),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .o_cmd       (cmd)
    );

    p1305_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_block_low  (in_ch.block_low),
        .i_block_high (in_ch.block_high),
        .i_block_len  (in_ch.block_len),
        .i_r_low      (r_key[p1305_pkg::REG_R_LOW]),
        .i_r_high     (r_key[p1305_pkg::REG_R_HIGH]),
        .i_s_low      (r_key[p1305_pkg::REG_S_LOW]),
        .i_s_high     (r_key[p1305_pkg::REG_S_HIGH]),
        .i_rst_n      (i_rst_n),
        .o_tag_low    (out_ch.tag_low),
        .o_tag_high   (out_ch.tag_high)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_poly1305_mac_tag_top.sv
// ----------------------------------------------------------------------------
// tb_poly1305_mac_tag_top
// Self-checking bench for the Poly1305 tag block: drives key writes and
// message blocks, predicts tags with wide modular arithmetic, and compares
// each tag word in order under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_poly1305_mac_tag_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [130:0] PRIME_P = 131'h3fffffffffffffffffffffffffffffffb;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned ITEM_GOAL = 1400;

    typedef struct packed {
        logic [63:0] tag_low;
        logic [63:0] tag_high;
    } t_tag;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    p1305_cfg_if cfg_if();
    p1305_in_if  blk_if();
    p1305_out_if tag_if();

    poly1305_mac_tag_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg_if.sink),
        .in_ch   (blk_if.sink),
        .out_ch  (tag_if.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [63:0]  key_r_lo, key_r_hi, key_s_lo, key_s_hi;
    logic [129:0] acc_mod_p;
    t_tag         tag_queue[$];

    int unsigned  errors = 0;
    int unsigned  cycles = 0;
    int unsigned  items_sent = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;

    initial begin
        cfg_if.valid = 1'b0;
        cfg_if.index = p1305_pkg::REG_R_LOW;
        cfg_if.data = '0;
        blk_if.valid = 1'b0;
        blk_if.block_low = '0;
        blk_if.block_high = '0;
        blk_if.block_len = '0;
        blk_if.is_last = 1'b0;
        tag_if.ready = 1'b0;
        key_r_lo = '0;
        key_r_hi = '0;
        key_s_lo = '0;
        key_s_hi = '0;
        acc_mod_p = '0;
    end

    // accumulate one block; returns 1 with the tag when the message ends
    function automatic bit absorb_block(input logic [63:0] lo, input logic [63:0] hi,
                                        input logic [4:0] len, input logic last,
                                        output t_tag tag);
        int unsigned n;
        logic [135:0] blk;
        logic [127:0] r_clamped;
        logic [127:0] sum;
        logic [263:0] prod;
        n = (len > 16) ? 16 : len;
        if (n != 0) begin
            blk = 136'({hi, lo});
            if (n < 16)
                blk = blk & ((136'd1 << (8 * n)) - 136'd1);
            blk = blk | (136'd1 << (8 * n));
            r_clamped = {key_r_hi & p1305_pkg::CLAMP_HIGH, key_r_lo & p1305_pkg::CLAMP_LOW};
            prod = (264'(acc_mod_p) + 264'(blk)) * 264'(r_clamped);
            acc_mod_p = 130'(prod % 264'(PRIME_P));
        end
        tag = '0;
        if (!last)
            return 1'b0;
        sum = acc_mod_p[127:0] + {key_s_hi, key_s_lo};
        tag.tag_low = sum[63:0];
        tag.tag_high = sum[127:64];
        acc_mod_p = '0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls and tag checking
    always @(posedge i_clk) begin
        t_tag want;
        if (i_rst_n && tag_if.valid && tag_if.ready) begin
            if (tag_queue.size() == 0) begin
                errors++;
                $display("%0t unexpected tag %h_%h", $time, tag_if.tag_high, tag_if.tag_low);
            end else begin
                want = tag_queue.pop_front();
                if (tag_if.tag_low !== want.tag_low) begin
                    errors++;
                    $display("%0t tag_low exp %h got %h", $time, want.tag_low, tag_if.tag_low);
                end
                if (tag_if.tag_high !== want.tag_high) begin
                    errors++;
                    $display("%0t tag_high exp %h got %h", $time, want.tag_high,
                             tag_if.tag_high);
                end
            end
        end
        tag_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_key(input logic [1:0] idx, input logic [63:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            p1305_pkg::REG_R_LOW:  key_r_lo = value;
            p1305_pkg::REG_R_HIGH: key_r_hi = value;
            p1305_pkg::REG_S_LOW:  key_s_lo = value;
            default:               key_s_hi = value;
        endcase
    endtask

    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input logic last);
        t_tag tag;
        bit gapped;
        gapped = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            if (!gapped)
                blk_if.valid <= 1'b0;
            gapped = 1;
            @(posedge i_clk);
        end
        blk_if.valid <= 1'b1;
        blk_if.block_low <= lo;
        blk_if.block_high <= hi;
        blk_if.block_len <= len;
        blk_if.is_last <= last;
        do @(posedge i_clk); while (!blk_if.ready);
        items_sent++;
        if (absorb_block(lo, hi, len, last, tag))
            tag_queue.insert(tag_queue.size(), tag);
    endtask

    // stop sending and let the block go idle before touching the keys
    task automatic drain;
        blk_if.valid <= 1'b0;
        while (tag_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_keys(input logic [63:0] rl, input logic [63:0] rh,
                             input logic [63:0] sl, input logic [63:0] sh);
        drain();
        write_key(p1305_pkg::REG_R_LOW, rl);
        write_key(p1305_pkg::REG_R_HIGH, rh);
        write_key(p1305_pkg::REG_S_LOW, sl);
        write_key(p1305_pkg::REG_S_HIGH, sh);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_directed;
        load_keys('1, '1, '1, '1);
        send_block('1, '1, 5'd16, 1'b0);      // full block, all ones
        send_block('1, '1, 5'd16, 1'b1);      // tag overflows past 2^128
        send_block('0, '0, 5'd0, 1'b1);       // empty message
        send_block('0, '0, 5'd16, 1'b1);
        send_block('1, '1, 5'd1, 1'b0);       // junk beyond the length is masked
        send_block('1, '1, 5'd8, 1'b0);
        send_block('1, '1, 5'd9, 1'b0);
        send_block('1, '1, 5'd0, 1'b0);       // empty, not last: no effect
        send_block('1, '1, 5'd15, 1'b1);
        send_block('1, '1, 5'd17, 1'b0);      // over-length clamps to 16
        send_block(rand64(), rand64(), 5'd31, 1'b0);
        send_block('1, '1, 5'd0, 1'b1);       // finish a multiple of 16
        load_keys('0, '0, '0, '0);
        send_block('1, '1, 5'd16, 1'b1);
        send_block(rand64(), rand64(), 5'd7, 1'b1);
        load_keys(rand64(), rand64(), '1, '0);
        send_block(rand64(), rand64(), 5'd16, 1'b0);
        send_block(rand64(), rand64(), 5'd12, 1'b1);
    endtask

    task automatic random_message;
        int unsigned nfull;
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 80) begin
            nfull = $urandom_range(4);
            repeat (nfull) send_block(rand64(), rand64(), 5'd16, 1'b0);
            if ($urandom_range(3) == 0)
                send_block(rand64(), rand64(), 5'd0, 1'b1);
            else
                send_block(rand64(), rand64(), 5'($urandom_range(16, 1)), 1'b1);
        end else begin
            // noise: arbitrary lengths and flags, including over-length values
            send_block(rand64(), rand64(), 5'($urandom_range(31)), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count);
        int unsigned target;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + count;
        while (items_sent < target) begin
            random_message();
            if ($urandom_range(29) == 0)
                drain();
        end
        // close any open message so the key change happens between messages
        send_block(rand64(), rand64(), 5'd0, 1'b1);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        load_keys(rand64(), rand64(), rand64(), rand64());
        test_random_phase(0, 0, ITEM_GOAL / 4);
        load_keys('1, '1, rand64(), '1);
        test_random_phase(52, 0, ITEM_GOAL / 4);
        load_keys(rand64(), rand64(), '0, rand64());
        test_random_phase(0, 52, ITEM_GOAL / 4);
        load_keys(rand64(), rand64(), rand64(), rand64());
        test_random_phase(36, 36, ITEM_GOAL / 4);
        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/p1305_pkg.sv
sv/p1305_if.sv
sv/p1305_dp.sv
sv/p1305_ctrl.sv
sv/poly1305_mac_tag_top.sv
tb/sv/tb_poly1305_mac_tag_top.sv
